>>> hw/rtl/pbmb_pkg.sv
// ----------------------------------------------------------------------------
// pbmb_pkg
// Shared types, constants and lookup functions for the pulse burst finder.
// ----------------------------------------------------------------------------
package pbmb_pkg;

  localparam int DEPTH   = 512;                 // sorted cells, max pulses per burst
  localparam int CNT_W   = $clog2(DEPTH + 1);   // counts 0..DEPTH
  localparam int HALF_W  = CNT_W - 1;           // counts 0..DEPTH/2
  localparam int DUR_W   = 16;
  localparam int TOT_W   = 26;                  // running total
  localparam int OTOT_W  = 25;                  // reported total
  localparam int BAND_W  = 3;
  localparam int KHZ_W   = 20;
  localparam int ADDR_W  = 3;
  localparam int CFG_W   = 16;

  localparam int TDATA_W = 80;                  // 74 bits of fields, padded to bytes

  // register indexes
  localparam logic [ADDR_W-1:0] REG_GAP_THRESHOLD = 3'd0;
  localparam logic [ADDR_W-1:0] REG_MIN_BURST     = 3'd1;
  localparam logic [ADDR_W-1:0] REG_MIN_VALID     = 3'd2;
  localparam logic [ADDR_W-1:0] REG_VALID_LOW     = 3'd3;
  localparam logic [ADDR_W-1:0] REG_VALID_HIGH    = 3'd4;

  // reset values
  localparam logic [DUR_W-1:0] GAP_RESET        = 16'd6000;
  localparam logic [CNT_W-1:0] MIN_BURST_RESET  = CNT_W'(4);
  localparam logic [CNT_W-1:0] MIN_VALID_RESET  = CNT_W'(12);
  localparam logic [DUR_W-1:0] VALID_LOW_RESET  = 16'd20;
  localparam logic [DUR_W-1:0] VALID_HIGH_RESET = 16'd20000;

  // input word kinds
  localparam logic MODE_PULSE = 1'b0;
  localparam logic MODE_REARM = 1'b1;

  // band codes
  localparam logic [BAND_W-1:0] BAND_315 = 3'd0;
  localparam logic [BAND_W-1:0] BAND_434 = 3'd1;
  localparam logic [BAND_W-1:0] BAND_390 = 3'd2;
  localparam logic [BAND_W-1:0] BAND_868 = 3'd3;
  localparam logic [BAND_W-1:0] BAND_915 = 3'd4;

  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } state_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;   // insert the broadcast duration in sorted place
    logic shift;    // move every cell one place toward the head
    logic clear;    // mark every cell empty
  } chain_ctrl_t;

  function automatic logic [BAND_W-1:0] band_of(input logic [DUR_W-1:0] m);
    logic [BAND_W-1:0] b;
    if (m < 16'd300)       b = BAND_315;
    else if (m < 16'd900)  b = BAND_434;
    else if (m < 16'd1600) b = BAND_390;
    else if (m < 16'd4000) b = BAND_868;
    else                   b = BAND_915;
    return b;
  endfunction

  function automatic logic [KHZ_W-1:0] khz_of(input logic [BAND_W-1:0] b);
    logic [KHZ_W-1:0] k;
    unique case (b)
      BAND_315: k = 20'd315000;
      BAND_434: k = 20'd434000;
      BAND_390: k = 20'd390000;
      BAND_868: k = 20'd868000;
      BAND_915: k = 20'd915000;
      default:  k = '0;
    endcase
    return k;
  endfunction

endpackage

>>> hw/rtl/pulse_burst_median_band_finder.sv
// ----------------------------------------------------------------------------
// pulse_burst_median_band_finder
// Groups pulse durations into bursts and reports the upper median band.
// ----------------------------------------------------------------------------
// no lock: a burst of at least min_burst pulses gives its word the cycle after the gap
// lock: the median at index valid_count/2 shifts to the head, then goes to the output register
// throughput: one input word per cycle, none while the chain drains
// input also waits while a result sits unread in the output register
// reset: registers return to defaults, unlocked, empty burst; cells empty at once
// ----------------------------------------------------------------------------
module pulse_burst_median_band_finder (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_we,
  input  logic [pbmb_pkg::ADDR_W-1:0]    cfg_addr,
  input  logic [pbmb_pkg::CFG_W-1:0]     cfg_data,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [pbmb_pkg::DUR_W-1:0]     s_tdata,   // [15:0] duration_us
  input  logic                           s_tuser,   // [0] mode
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [15:0] median_us, [18:16] band, [38:19] freq_khz, [48:39] burst_pulses,
  // [73:49] burst_total_us, [79:74] zero
  output logic [pbmb_pkg::TDATA_W-1:0]   m_tdata,
  output logic                           m_tuser    // [0] locked
);

  // configuration registers
  logic [pbmb_pkg::DUR_W-1:0] gap_threshold;
  logic [pbmb_pkg::CNT_W-1:0] min_burst;
  logic [pbmb_pkg::CNT_W-1:0] min_valid;
  logic [pbmb_pkg::DUR_W-1:0] valid_low;
  logic [pbmb_pkg::DUR_W-1:0] valid_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_threshold <= pbmb_pkg::GAP_RESET;
      min_burst     <= pbmb_pkg::MIN_BURST_RESET;
      min_valid     <= pbmb_pkg::MIN_VALID_RESET;
      valid_low     <= pbmb_pkg::VALID_LOW_RESET;
      valid_high    <= pbmb_pkg::VALID_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pbmb_pkg::REG_GAP_THRESHOLD: gap_threshold <= cfg_data;
        pbmb_pkg::REG_MIN_BURST:     min_burst     <= cfg_data[pbmb_pkg::CNT_W-1:0];
        pbmb_pkg::REG_MIN_VALID:     min_valid     <= cfg_data[pbmb_pkg::CNT_W-1:0];
        pbmb_pkg::REG_VALID_LOW:     valid_low     <= cfg_data;
        pbmb_pkg::REG_VALID_HIGH:    valid_high    <= cfg_data;
        default: ;  // unknown index, ignored
      endcase
    end
  end

  // burst state
  pbmb_pkg::state_t           state, state_next;
  logic                       lock_flag, lock_flag_next;
  logic [pbmb_pkg::CNT_W-1:0] stored_count, stored_count_next;
  logic [pbmb_pkg::CNT_W-1:0] valid_count, valid_count_next;
  logic [pbmb_pkg::TOT_W-1:0] running_total, running_total_next;
  logic [pbmb_pkg::HALF_W-1:0] drain_cnt, drain_cnt_next;

  // snapshot of the closed burst kept while the chain drains
  logic [pbmb_pkg::CNT_W-1:0]  snap_pulses, snap_pulses_next;
  logic [pbmb_pkg::OTOT_W-1:0] snap_total, snap_total_next;

  // output register
  logic                          out_valid, out_valid_next;
  logic                          out_locked, out_locked_next;
  logic [pbmb_pkg::DUR_W-1:0]    out_median, out_median_next;
  logic [pbmb_pkg::BAND_W-1:0]   out_band, out_band_next;
  logic [pbmb_pkg::KHZ_W-1:0]    out_khz, out_khz_next;
  logic [pbmb_pkg::CNT_W-1:0]    out_pulses, out_pulses_next;
  logic [pbmb_pkg::OTOT_W-1:0]   out_total, out_total_next;

  pbmb_pkg::chain_ctrl_t      chain_ctrl;
  logic [pbmb_pkg::DUR_W-1:0] head_val;
  logic [pbmb_pkg::BAND_W-1:0] head_band;

  logic accept;
  logic is_gap;
  logic qualifies;
  logic burst_judged;
  logic lock_ok;

  // the output slot must be free (or freeing) before a word that may produce a result
  assign s_tready  = (state == pbmb_pkg::ST_RUN) && (!out_valid || m_tready);
  assign accept    = s_tvalid && s_tready;
  assign is_gap    = s_tdata >= gap_threshold;
  assign qualifies = (s_tdata > valid_low) && (s_tdata < valid_high);
  assign burst_judged = stored_count >= min_burst;
  assign lock_ok   = (valid_count != '0) && (valid_count >= min_valid);
  assign head_band = pbmb_pkg::band_of(head_val);

  always_comb begin
    state_next         = state;
    lock_flag_next     = lock_flag;
    stored_count_next  = stored_count;
    valid_count_next   = valid_count;
    running_total_next = running_total;
    drain_cnt_next     = drain_cnt;
    snap_pulses_next   = snap_pulses;
    snap_total_next    = snap_total;
    out_valid_next     = out_valid && !m_tready;
    out_locked_next    = out_locked;
    out_median_next    = out_median;
    out_band_next      = out_band;
    out_khz_next       = out_khz;
    out_pulses_next    = out_pulses;
    out_total_next     = out_total;
    chain_ctrl         = '0;

    unique case (state)
      pbmb_pkg::ST_RUN: begin
        if (accept) begin
          if (s_tuser == pbmb_pkg::MODE_REARM) begin
            lock_flag_next     = 1'b0;
            stored_count_next  = '0;
            valid_count_next   = '0;
            running_total_next = '0;
            chain_ctrl.clear   = 1'b1;
          end else if (!lock_flag) begin
            if (is_gap) begin
              stored_count_next  = '0;
              valid_count_next   = '0;
              running_total_next = '0;
              if (burst_judged && lock_ok) begin
                // median sits at index valid_count/2 of the ascending chain
                snap_pulses_next = stored_count;
                snap_total_next  = running_total[pbmb_pkg::OTOT_W-1:0];
                drain_cnt_next   = valid_count[pbmb_pkg::CNT_W-1:1];
                state_next       = pbmb_pkg::ST_DRAIN;
              end else begin
                chain_ctrl.clear = 1'b1;
                if (burst_judged) begin
                  out_valid_next  = 1'b1;
                  out_locked_next = 1'b0;
                  out_median_next = '0;
                  out_band_next   = '0;
                  out_khz_next    = '0;
                  out_pulses_next = stored_count;
                  out_total_next  = running_total[pbmb_pkg::OTOT_W-1:0];
                end
              end
            end else if (stored_count < pbmb_pkg::CNT_W'(pbmb_pkg::DEPTH)) begin
              stored_count_next  = stored_count + 1'b1;
              running_total_next = running_total + pbmb_pkg::TOT_W'(s_tdata);
              if (qualifies) begin
                valid_count_next  = valid_count + 1'b1;
                chain_ctrl.insert = 1'b1;
              end
            end
          end
        end
      end

      pbmb_pkg::ST_DRAIN: begin
        if (drain_cnt != '0) begin
          chain_ctrl.shift = 1'b1;
          drain_cnt_next   = drain_cnt - 1'b1;
        end else begin
          out_valid_next   = 1'b1;
          out_locked_next  = 1'b1;
          out_median_next  = head_val;
          out_band_next    = head_band;
          out_khz_next     = pbmb_pkg::khz_of(head_band);
          out_pulses_next  = snap_pulses;
          out_total_next   = snap_total;
          lock_flag_next   = 1'b1;
          chain_ctrl.clear = 1'b1;
          state_next       = pbmb_pkg::ST_RUN;
        end
      end

      default: state_next = pbmb_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pbmb_pkg::ST_RUN;
      lock_flag     <= 1'b0;
      stored_count  <= '0;
      valid_count   <= '0;
      running_total <= '0;
      drain_cnt     <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      lock_flag     <= lock_flag_next;
      stored_count  <= stored_count_next;
      valid_count   <= valid_count_next;
      running_total <= running_total_next;
      drain_cnt     <= drain_cnt_next;
      out_valid     <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    snap_pulses <= snap_pulses_next;
    snap_total  <= snap_total_next;
    out_locked  <= out_locked_next;
    out_median  <= out_median_next;
    out_band    <= out_band_next;
    out_khz     <= out_khz_next;
    out_pulses  <= out_pulses_next;
    out_total   <= out_total_next;
  end

  // sorted insertion chain of qualifying durations
  pbmb_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (chain_ctrl),
    .din      (s_tdata),
    .head_val (head_val)
  );

  assign m_tvalid = out_valid;
  assign m_tuser  = out_locked;
  assign m_tdata  = {6'd0, out_total, out_pulses, out_khz, out_band, out_median};

  // no input taken while the chain drains
  a_drain_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == pbmb_pkg::ST_DRAIN) |-> !s_tready)
    else $error("input accepted during drain");

  // a drain only starts from an unlocked block and ends in lock
  a_drain_unlocked: assert property (@(posedge clk) disable iff (rst)
    (state == pbmb_pkg::ST_DRAIN) |-> !lock_flag)
    else $error("drain while locked");

  a_lock_after_drain: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == pbmb_pkg::ST_DRAIN && state == pbmb_pkg::ST_RUN) |->
      (lock_flag && out_valid && out_locked))
    else $error("drain ended without locked result");

  a_counts: assert property (@(posedge clk) disable iff (rst)
    (valid_count <= stored_count) &&
    (stored_count <= pbmb_pkg::CNT_W'(pbmb_pkg::DEPTH)))
    else $error("burst counters out of range");

  a_unlocked_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_locked) |-> (out_median == '0 && out_khz == '0))
    else $error("unlocked result carries band data");

endmodule

>>> hw/rtl/pbmb_cell.sv
// ----------------------------------------------------------------------------
// pbmb_cell
// One cell of the sorted insertion chain: holds a duration and an occupied flag.
// ----------------------------------------------------------------------------
module pbmb_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  pbmb_pkg::chain_ctrl_t       ctrl,
  input  logic [pbmb_pkg::DUR_W-1:0]  din,
  input  logic [pbmb_pkg::DUR_W-1:0]  left_val,
  input  logic                        left_occ,
  input  logic                        left_gt,
  input  logic [pbmb_pkg::DUR_W-1:0]  right_val,
  input  logic                        right_occ,
  output logic [pbmb_pkg::DUR_W-1:0]  val,
  output logic                        occ,
  output logic                        gt
);

  // empty cells sort as larger than anything
  assign gt = !occ || (val > din);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.clear) begin
      occ <= 1'b0;
    end else if (ctrl.shift) begin
      occ <= right_occ;
    end else if (ctrl.insert) begin
      if (left_gt) begin
        occ <= left_occ;
      end else if (gt) begin
        occ <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      val <= right_val;
    end else if (ctrl.insert) begin
      if (left_gt) begin
        val <= left_val;
      end else if (gt) begin
        val <= din;
      end
    end
  end

endmodule

>>> hw/rtl/pbmb_chain.sv
// ----------------------------------------------------------------------------
// pbmb_chain
// Row of sorting cells, ascending from the head; head value is cell zero.
// ----------------------------------------------------------------------------
module pbmb_chain (
  input  logic                        clk,
  input  logic                        rst,
  input  pbmb_pkg::chain_ctrl_t       ctrl,
  input  logic [pbmb_pkg::DUR_W-1:0]  din,
  output logic [pbmb_pkg::DUR_W-1:0]  head_val
);

  logic [pbmb_pkg::DUR_W-1:0] vals [pbmb_pkg::DEPTH];
  logic                       occs [pbmb_pkg::DEPTH];
  logic                       gts  [pbmb_pkg::DEPTH];

  for (genvar i = 0; i < pbmb_pkg::DEPTH; i++) begin : g_cell
    logic [pbmb_pkg::DUR_W-1:0] lv;
    logic                       lo;
    logic                       lg;
    logic [pbmb_pkg::DUR_W-1:0] rv;
    logic                       ro;

    if (i == 0) begin : g_first
      assign lv = '0;
      assign lo = 1'b0;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = vals[i-1];
      assign lo = occs[i-1];
      assign lg = gts[i-1];
    end

    if (i == pbmb_pkg::DEPTH - 1) begin : g_last
      assign rv = '0;
      assign ro = 1'b0;
    end else begin : g_inner
      assign rv = vals[i+1];
      assign ro = occs[i+1];
    end

    pbmb_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .din       (din),
      .left_val  (lv),
      .left_occ  (lo),
      .left_gt   (lg),
      .right_val (rv),
      .right_occ (ro),
      .val       (vals[i]),
      .occ       (occs[i]),
      .gt        (gts[i])
    );
  end

  assign head_val = vals[0];

endmodule
